FILE: src/assert_macros.svh
// Assertion macros shared by the checkers of this block.
// Each macro samples on clk and is quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ps2mt_pkg.sv
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Types and constants of the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

    localparam int COORD_BITS = 12;
    localparam int LIMIT_BITS = 12;
    localparam int BYTE_BITS  = 8;
    localparam int BTN_BITS   = 3;
    localparam int SUM_BITS   = ((COORD_BITS > LIMIT_BITS) ? COORD_BITS : LIMIT_BITS) + 2;

    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [LIMIT_BITS-1:0] RESET_X_LIMIT = LIMIT_BITS'(640);
    localparam logic [LIMIT_BITS-1:0] RESET_Y_LIMIT = LIMIT_BITS'(480);
    localparam logic [COORD_BITS-1:0] RESET_X_POS   = COORD_BITS'(640 / 2);
    localparam logic [COORD_BITS-1:0] RESET_Y_POS   = COORD_BITS'(480 / 2);

    // register index, taken from paddr[2]
    localparam logic REG_X_LIMIT = 1'b0;
    localparam logic REG_Y_LIMIT = 1'b1;

    // header byte bit positions
    localparam int HDR_SIGN_X = 4;
    localparam int HDR_SIGN_Y = 5;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_DELTA_X = 2'd1,
        PH_DELTA_Y = 2'd2
    } phase_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [BTN_BITS-1:0]   buttons;
        logic                  packet_done;
    } result_t;

endpackage

FILE: src/ps2_mouse_packet_tracker.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Decodes three-byte PS/2 mouse packets into a clamped cursor position.
// ----------------------------------------------------------------------------
// Takes one received byte per clock cycle while byte_stall is low and returns
// one registered result per byte. The sign extension, the add and the clamp of
// a delta byte sit between the cursor registers and the result buffer, which
// holds two results; byte_stall rises only while both entries wait on
// result_stall. The first byte after reset is dropped (its result repeats the
// reset position), then bytes group as header, X delta, Y delta. x_limit and
// y_limit sit at byte addresses 0 and 4; write them only while no request is
// in flight.
module ps2_mouse_packet_tracker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ps2mt_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [ps2mt_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [ps2mt_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                pready,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  logic [ps2mt_pkg::BYTE_BITS-1:0]     rx_byte,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [ps2mt_pkg::COORD_BITS-1:0]    pos_x,
    output logic [ps2mt_pkg::COORD_BITS-1:0]    pos_y,
    output logic [ps2mt_pkg::BTN_BITS-1:0]      buttons,
    output logic                                packet_done
);
    import ps2mt_pkg::*;

    localparam logic signed [SUM_BITS-1:0] COORD_MAX_S = SUM_BITS'((1 << COORD_BITS) - 1);

    logic [LIMIT_BITS-1:0] x_limit_reg;
    logic [LIMIT_BITS-1:0] y_limit_reg;
    logic                  cfg_write;

    phase_t                phase_reg, phase_next;
    logic                  skip_reg, skip_next;
    logic                  sign_x_reg, sign_x_next;
    logic                  sign_y_reg, sign_y_next;
    logic [COORD_BITS-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_BITS-1:0] cursor_y_reg, cursor_y_next;
    logic [BTN_BITS-1:0]   button_reg, button_next;
    logic                  done_next;

    result_t head_reg, skid_reg, new_result;
    logic    head_valid_reg, skid_valid_reg;
    logic    byte_accept, result_pop;

    function automatic logic [COORD_BITS-1:0] apply_delta(
        input logic [COORD_BITS-1:0] pos,
        input logic [BYTE_BITS-1:0]  delta_byte,
        input logic                  neg,
        input logic [LIMIT_BITS-1:0] limit
    );
        logic signed [SUM_BITS-1:0] sum;
        logic signed [SUM_BITS-1:0] lim;
        sum = $signed({{(SUM_BITS-COORD_BITS){1'b0}}, pos})
            + $signed({{(SUM_BITS-BYTE_BITS){neg}}, delta_byte});
        lim = $signed({{(SUM_BITS-LIMIT_BITS){1'b0}}, limit});
        if (lim > COORD_MAX_S)
        begin
            lim = COORD_MAX_S;
        end
        if (sum > lim)
        begin
            sum = lim;
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        return sum[COORD_BITS-1:0];
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_X_LIMIT: prdata = APB_DATA_BITS'(x_limit_reg);
            REG_Y_LIMIT: prdata = APB_DATA_BITS'(y_limit_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= RESET_X_LIMIT;
            y_limit_reg <= RESET_Y_LIMIT;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_X_LIMIT)
            begin
                x_limit_reg <= pwdata[LIMIT_BITS-1:0];
            end
            else
            begin
                y_limit_reg <= pwdata[LIMIT_BITS-1:0];
            end
        end
    end

    // handshakes
    assign byte_stall  = skid_valid_reg;
    assign byte_accept = byte_valid && !byte_stall;
    assign result_pop  = head_valid_reg && !result_stall;

    // packet phase: next state
    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        if (byte_accept)
        begin
            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_DELTA_X: phase_next = PH_DELTA_Y;
                    PH_DELTA_Y: phase_next = PH_HEADER;
                    default:    phase_next = PH_DELTA_X;
                endcase
            end
        end
    end

    // packet phase: datapath
    always_comb
    begin
        sign_x_next   = sign_x_reg;
        sign_y_next   = sign_y_reg;
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        button_next   = button_reg;
        done_next     = 1'b0;
        if (!skip_reg)
        begin
            case (phase_reg)
                PH_DELTA_X:
                begin
                    cursor_x_next = apply_delta(cursor_x_reg, rx_byte, sign_x_reg, x_limit_reg);
                end
                PH_DELTA_Y:
                begin
                    cursor_y_next = apply_delta(cursor_y_reg, rx_byte, sign_y_reg, y_limit_reg);
                    done_next     = 1'b1;
                end
                default:
                begin
                    button_next = rx_byte[BTN_BITS-1:0];
                    sign_x_next = rx_byte[HDR_SIGN_X];
                    sign_y_next = rx_byte[HDR_SIGN_Y];
                end
            endcase
        end
        new_result.pos_x       = cursor_x_next;
        new_result.pos_y       = cursor_y_next;
        new_result.buttons     = button_next;
        new_result.packet_done = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            skip_reg     <= 1'b1;
            sign_x_reg   <= 1'b0;
            sign_y_reg   <= 1'b0;
            cursor_x_reg <= RESET_X_POS;
            cursor_y_reg <= RESET_Y_POS;
            button_reg   <= '0;
        end
        else if (byte_accept)
        begin
            phase_reg    <= phase_next;
            skip_reg     <= skip_next;
            sign_x_reg   <= sign_x_next;
            sign_y_reg   <= sign_y_next;
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            button_reg   <= button_next;
        end
    end

    // two-entry result buffer: head drives the outputs, skid catches a result
    // that arrives while the head is held
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!head_valid_reg || result_pop)
        begin
            head_valid_reg <= skid_valid_reg || byte_accept;
            skid_valid_reg <= 1'b0;
        end
        else if (byte_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!head_valid_reg || result_pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
            end
            else if (byte_accept)
            begin
                head_reg <= new_result;
            end
        end
        else if (byte_accept)
        begin
            skid_reg <= new_result;
        end
    end

    assign result_valid = head_valid_reg;
    assign pos_x        = head_reg.pos_x;
    assign pos_y        = head_reg.pos_y;
    assign buttons      = head_reg.buttons;
    assign packet_done  = head_reg.packet_done;

endmodule

FILE: src/ps2mt_checker.sv
// ----------------------------------------------------------------------------
// ps2mt_checker
// Port-level checks of the PS/2 mouse packet tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ps2mt_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             byte_stall,
    input logic                             result_valid,
    input logic                             result_stall,
    input logic [ps2mt_pkg::COORD_BITS-1:0] pos_x,
    input logic [ps2mt_pkg::COORD_BITS-1:0] pos_y,
    input logic [ps2mt_pkg::BTN_BITS-1:0]   buttons,
    input logic                             packet_done
);
    import ps2mt_pkg::*;

    logic                  result_take;
    logic                  seen_reg;
    logic                  last_done_reg;
    logic [COORD_BITS-1:0] last_x_reg;

    assign result_take = result_valid && !result_stall;

    // remember the last result delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            last_done_reg <= 1'b0;
            last_x_reg    <= RESET_X_POS;
        end
        else if (result_take)
        begin
            seen_reg      <= 1'b1;
            last_done_reg <= packet_done;
            last_x_reg    <= pos_x;
        end
    end

    `ASSERT_NEXT(a_result_hold, result_valid && result_stall,
        result_valid && $stable(pos_x) && $stable(pos_y) && $stable(buttons)
        && $stable(packet_done), "stalled result changed")
    `ASSERT_ALWAYS(a_stall_only_full, !byte_stall || result_valid,
        "byte_stall high with an empty result buffer")
    `ASSERT_ALWAYS(a_done_spacing, !(result_take && last_done_reg && packet_done),
        "two completed packets in a row")
    `ASSERT_ALWAYS(a_x_still_on_done,
        !(result_take && seen_reg && packet_done) || (pos_x == last_x_reg),
        "X position moved on a Y delta byte")

endmodule

bind ps2_mouse_packet_tracker ps2mt_checker u_ps2mt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .buttons      (buttons),
    .packet_done  (packet_done)
);

FILE: tb/tb_ps2_mouse_packet_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_mouse_packet_tracker
// Self-checking bench for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
// Bytes are fed from a queue through the valid/stall request channel. Each
// accepted byte runs through a local cursor tracker that yields the expected
// position, buttons and packet flag, and every result taken from the block is
// compared with the oldest expectation. The limits are rewritten over APB
// between phases, with readback, and sender and receiver idle at random.
module tb_ps2_mouse_packet_tracker;
    import ps2mt_pkg::*;

    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr = '0;
    logic [APB_DATA_BITS-1:0] pwdata = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     byte_valid = 1'b0;
    logic                     byte_stall;
    logic [BYTE_BITS-1:0]     rx_byte = '0;
    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic [COORD_BITS-1:0]    pos_x;
    logic [COORD_BITS-1:0]    pos_y;
    logic [BTN_BITS-1:0]      buttons;
    logic                     packet_done;

    ps2_mouse_packet_tracker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .rx_byte      (rx_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .buttons      (buttons),
        .packet_done  (packet_done)
    );

    // local copy of the tracker state and limits
    logic [LIMIT_BITS-1:0] trk_x_limit = RESET_X_LIMIT;
    logic [LIMIT_BITS-1:0] trk_y_limit = RESET_Y_LIMIT;
    phase_t                trk_phase = PH_HEADER;
    logic                  trk_skip = 1'b1;
    logic                  trk_sign_x = 1'b0;
    logic                  trk_sign_y = 1'b0;
    logic [COORD_BITS-1:0] trk_x = RESET_X_POS;
    logic [COORD_BITS-1:0] trk_y = RESET_Y_POS;
    logic [BTN_BITS-1:0]   trk_buttons = '0;

    logic [BYTE_BITS-1:0] byte_q[$];
    result_t              cursor_q[$];
    int                   pushed_cnt = 0;
    int                   sent_cnt = 0;
    int                   took_cnt = 0;
    int                   err_cnt = 0;
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;

    function automatic logic [COORD_BITS-1:0] move_axis(logic [COORD_BITS-1:0] pos,
                                                        logic [BYTE_BITS-1:0] delta,
                                                        logic neg,
                                                        logic [LIMIT_BITS-1:0] lim);
        int sum;
        int top;
        top = int'(lim);
        if (top > COORD_MAX)
            top = COORD_MAX;
        sum = int'(pos) + int'(delta) - (neg ? 256 : 0);
        if (sum > top)
            sum = top;
        if (sum < 0)
            sum = 0;
        return COORD_BITS'(sum);
    endfunction

    function automatic result_t track_byte(logic [BYTE_BITS-1:0] b);
        result_t r;
        r.packet_done = 1'b0;
        if (trk_skip)
        begin
            trk_skip = 1'b0;
        end
        else if (trk_phase == PH_DELTA_X)
        begin
            trk_x = move_axis(trk_x, b, trk_sign_x, trk_x_limit);
            trk_phase = PH_DELTA_Y;
        end
        else if (trk_phase == PH_DELTA_Y)
        begin
            trk_y = move_axis(trk_y, b, trk_sign_y, trk_y_limit);
            trk_phase = PH_HEADER;
            r.packet_done = 1'b1;
        end
        else
        begin
            trk_buttons = b[BTN_BITS-1:0];
            trk_sign_x = b[HDR_SIGN_X];
            trk_sign_y = b[HDR_SIGN_Y];
            trk_phase = PH_DELTA_X;
        end
        r.pos_x = trk_x;
        r.pos_y = trk_y;
        r.buttons = trk_buttons;
        return r;
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    // driver: hold a request until it is taken, idle only between requests
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!byte_valid || took_cnt == sent_cnt)
            begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_valid <= 1'b1;
                    rx_byte <= byte_q.pop_front();
                    sent_cnt <= sent_cnt + 1;
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: predict on byte acceptance, check on result acceptance
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                cursor_q.push_back(track_byte(rx_byte));
                took_cnt = took_cnt + 1;
            end
            if (result_valid && !result_stall)
            begin
                got.pos_x = pos_x;
                got.pos_y = pos_y;
                got.buttons = buttons;
                got.packet_done = packet_done;
                if (cursor_q.size() == 0)
                begin
                    err_cnt = err_cnt + 1;
                    $display("%0t: unexpected result x=%0d y=%0d btn=%0d done=%0d",
                             $time, got.pos_x, got.pos_y, got.buttons, got.packet_done);
                end
                else
                begin
                    want = cursor_q.pop_front();
                    if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                        got.buttons !== want.buttons ||
                        got.packet_done !== want.packet_done)
                    begin
                        err_cnt = err_cnt + 1;
                        $display("%0t: mismatch expected x=%0d y=%0d btn=%0d done=%0d",
                                 $time, want.pos_x, want.pos_y, want.buttons,
                                 want.packet_done);
                        $display("%0t:          actual   x=%0d y=%0d btn=%0d done=%0d",
                                 $time, got.pos_x, got.pos_y, got.buttons,
                                 got.packet_done);
                    end
                end
            end
        end
    end

    task automatic push_byte(input logic [BYTE_BITS-1:0] b);
        byte_q.push_back(b);
        pushed_cnt = pushed_cnt + 1;
    endtask

    // wait until every request is taken and every result checked
    task automatic drain();
        while (took_cnt != pushed_cnt || cursor_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic idx, input logic [LIMIT_BITS-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_ADDR_BITS'({idx, 2'b00});
        pwdata <= APB_DATA_BITS'(val);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_X_LIMIT)
            trk_x_limit = val;
        else
            trk_y_limit = val;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[LIMIT_BITS-1:0] !== val)
        begin
            err_cnt = err_cnt + 1;
            $display("%0t: readback of register %0d expected %0d actual %0d",
                     $time, idx, val, prdata[LIMIT_BITS-1:0]);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [BYTE_BITS-1:0] delta_byte(bit upward);
        if (upward && $urandom_range(1) == 0)
            return BYTE_BITS'($urandom_range(255, 100));
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return BYTE_BITS'($urandom);
        endcase
    endfunction

    // follow packet slots so headers and deltas land where they belong
    task automatic push_random(input int n, input bit upward);
        logic [BYTE_BITS-1:0] b;
        for (int i = 0; i < n; i++)
        begin
            if ((pushed_cnt - 1) % 3 == 0)
            begin
                b = BYTE_BITS'($urandom);
                if (upward && $urandom_range(9) != 0)
                    b = b & ~8'h30;
            end
            else
            begin
                b = delta_byte(upward);
            end
            push_byte(b);
        end
    endtask

    task automatic set_limits(input logic [LIMIT_BITS-1:0] xl,
                              input logic [LIMIT_BITS-1:0] yl);
        write_limit(REG_X_LIMIT, xl);
        write_limit(REG_Y_LIMIT, yl);
    endtask

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // dropped first byte, then extremes of header and deltas
        push_byte(8'hFF);
        push_byte(8'h00); push_byte(8'h7F); push_byte(8'h7F);
        push_byte(8'h07); push_byte(8'hFF); push_byte(8'hFF);
        push_byte(8'h30); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'h80);
        push_byte(8'hC8); push_byte(8'h01); push_byte(8'h00);
        push_byte(8'h30); push_byte(8'h00); push_byte(8'h00);
        push_byte(8'h05); push_byte(8'hFF); push_byte(8'hFF);
        // sender pauses here until every expected result is in
        drain();

        set_limits(12'd640, 12'd480);
        push_random(250, 1'b0);
        drain();

        set_limits(12'd4095, 12'd4095);
        send_idle_pct = 46;
        push_random(300, 1'b1);
        drain();

        // lower the limits below the current position
        set_limits(12'd1, 12'd1);
        send_idle_pct = 0;
        recv_stall_pct = 46;
        push_random(200, 1'b0);
        drain();

        set_limits(12'd0, 12'd0);
        send_idle_pct = 29;
        recv_stall_pct = 29;
        push_random(100, 1'b0);
        drain();

        set_limits(12'd2000, 12'd3000);
        push_random(300, 1'b1);
        drain();

        set_limits(12'd4095, 12'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_random(150, 1'b0);
        drain();

        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
